/* hdl/gmm_pkg.sv */
// Shared types and constants of the gray max-min window filter.
// No dependencies; gmm_cell and the top level import this package.
package gmm_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

   localparam int CSR_DATA_W = 11;
   localparam int HEIGHT_W   = 11;
   localparam int MAX_HEIGHT = 1024;

   // Input kinds carried in tuser.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // Q0.16 gray weights; they sum to one.
   localparam logic [15:0] WEIGHT_RED   = 16'd13933;
   localparam logic [15:0] WEIGHT_GREEN = 16'd46871;
   localparam logic [15:0] WEIGHT_BLUE  = 16'd4732;

   localparam logic [7:0] GRAY_MAX = 8'd255;
   localparam logic [7:0] GRAY_MIN = 8'd0;

   // Result queue.
   localparam int FIFO_AW    = 3;
   localparam int FIFO_DEPTH = 8;

   // Column extremes handed along the cell row.
   typedef struct packed {
      logic [7:0] max_v;
      logic [7:0] min_v;
   } mm_type;

endpackage

/* hdl/gmm_ram.sv */
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
module gmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/gmm_cell.sv */
// One cell of the horizontal window row: holds the extremes of one column.
// Depends on gmm_pkg.
module gmm_cell (
   input  logic           clock,
   input  logic           shift,
   input  gmm_pkg::mm_type d_in,
   output gmm_pkg::mm_type q_out
);
   import gmm_pkg::*;

   mm_type hold_ff;

   // The cell takes its neighbor's column whenever the stream advances.
   always_ff @(posedge clock) begin
      if (shift) begin
         hold_ff <= d_in;
      end
   end

   assign q_out = hold_ff;

endmodule

/* hdl/gray_maxmin_window_filter_top.sv */
// Top level of the gray max-min window filter.
// Depends on gmm_pkg, gmm_ram and gmm_cell.
//
// Usage. Words on the req_ channel carry one BGR pixel (tuser = 0) or a drain
// request (tuser = 1) in raster order. Each pixel is turned into an 8-bit gray
// value and for each image position the block returns on the rsp_ channel the
// window maximum minus the window minimum over a (2R+1)x(2R+1) square, with
// positions outside the image left out. tlast marks the last result of a frame.
// Results lag the pixels by R*W+R positions, so after the last pixel the user
// sends drain words, one per remaining result. The csr_ port writes width,
// height and radius; they are sampled when a frame starts.
// Throughput is one word per cycle while req_tready is high. On its way to rsp_
// a result passes the stage 1 registers (gray weighting and line store read),
// the stage 2 taps (column extremes), the shift of the cell row and the window
// extremes into the result queue. When R*W+R exceeds W*H the block holds
// req_tready low after the last pixel while the line stores advance past the
// frame. An eight-word result queue parts the two sides; when the receiver
// stalls, tready falls only once the queue and the words in flight fill it.
// Reset empties the queue and the pipeline, restores the register defaults and
// needs no clearing pass of the line stores.
module gray_maxmin_window_filter_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // blue [7:0], green [15:8], red [23:16]
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // filtered_value [7:0]
   output logic        rsp_tlast,  // frame_end
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wdata
);
   import gmm_pkg::*;

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int RB = $clog2(MAX_RADIUS + 1);
   localparam int NT = 2 * MAX_RADIUS + 1;
   localparam int NR = 2 * MAX_RADIUS;
   localparam int LB = $clog2(MAX_RADIUS * (MAX_WIDTH + 1) + 1);
   localparam int YB = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 2);

   // Configuration registers.
   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic [1:0]            radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd128;
         height_ff <= 11'd128;
         radius_ff <= 2'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_IMAGE_WIDTH:   width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT:  height_ff <= csr_wdata;
            REG_WINDOW_RADIUS: radius_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Saturated register values, as a frame would sample them now.
   logic [WB-1:0]       w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [RB-1:0]       r_eff;
   logic [LB-1:0]       lat_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WB'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WB'(MAX_WIDTH);
      end else begin
         w_eff = WB'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      if (int'(radius_ff) > MAX_RADIUS) begin
         r_eff = RB'(MAX_RADIUS);
      end else begin
         r_eff = RB'(radius_ff);
      end
      lat_eff = LB'(r_eff) * LB'(w_eff) + LB'(r_eff);
   end

   // Frame control state.
   logic                idle_ff, idle_in;
   logic                pix_done_ff, pix_done_in;
   logic [CB-1:0]       vx_ff, vx_in;
   logic [YB-1:0]       vy_ff, vy_in;
   logic [CB-1:0]       ocol_ff, ocol_in;
   logic [HEIGHT_W-1:0] orow_ff, orow_in;
   logic [LB-1:0]       lead_ff, lead_in;
   logic [WB-1:0]       lw_ff;
   logic [HEIGHT_W-1:0] lh_ff;
   logic [RB-1:0]       lr_ff;

   // While no frame is open the registers pass straight through, so that the
   // first pixel of a frame already sees the values written before it.
   logic [WB-1:0]       cur_w;
   logic [HEIGHT_W-1:0] cur_h;
   logic [RB-1:0]       cur_r;
   logic [LB-1:0]       lead_cur;

   assign cur_w    = idle_ff ? w_eff   : lw_ff;
   assign cur_h    = idle_ff ? h_eff   : lh_ff;
   assign cur_r    = idle_ff ? r_eff   : lr_ff;
   assign lead_cur = idle_ff ? lat_eff : lead_ff;

   // Pipeline and queue occupancy.
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [FIFO_AW:0]   fifo_cnt_ff;
   logic [FIFO_AW:0]   occupancy;
   logic               space_ok, catchup, accept, is_pixel, is_drain, step, emit, fend;

   assign occupancy = fifo_cnt_ff + (FIFO_AW + 1)'(s1_valid_ff)
                    + (FIFO_AW + 1)'(s2_valid_ff) + (FIFO_AW + 1)'(s3_valid_ff);
   assign space_ok  = int'(occupancy) < FIFO_DEPTH;

   // After the last pixel the line stores are walked forward without input
   // until the first pending result lines up with the stream position.
   assign catchup    = !idle_ff && pix_done_ff && (lead_ff != '0);
   assign req_tready = space_ok && !catchup;
   assign accept     = req_tvalid && req_tready;
   assign is_pixel   = accept && !pix_done_ff && (req_tuser == KIND_PIXEL);
   // Once all pixels are in, every word is a drain, pixel or not.
   assign is_drain   = accept && pix_done_ff;
   assign step       = is_pixel || is_drain || (catchup && space_ok);
   assign emit       = is_drain || (is_pixel && (lead_cur == '0));
   assign fend       = emit && (WB'(ocol_ff) == cur_w - WB'(1))
                            && (orow_ff == cur_h - HEIGHT_W'(1));

   always_comb begin
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      ocol_in     = ocol_ff;
      orow_in     = orow_ff;
      pix_done_in = pix_done_ff;
      lead_in     = lead_cur;
      idle_in     = idle_ff;
      if (step) begin
         idle_in = 1'b0;
         if (lead_cur != '0) begin
            lead_in = lead_cur - LB'(1);
         end
         if (WB'(vx_ff) + WB'(1) == cur_w) begin
            vx_in = '0;
            vy_in = vy_ff + YB'(1);
         end else begin
            vx_in = vx_ff + CB'(1);
         end
         if (is_pixel && (WB'(vx_ff) + WB'(1) == cur_w)
             && (int'(vy_ff) + 1 == int'(cur_h))) begin
            pix_done_in = 1'b1;
         end
      end
      if (emit) begin
         if (WB'(ocol_ff) + WB'(1) == cur_w) begin
            ocol_in = '0;
            orow_in = orow_ff + HEIGHT_W'(1);
         end else begin
            ocol_in = ocol_ff + CB'(1);
         end
      end
      // The last result closes the frame and rewinds every counter.
      if (fend) begin
         vx_in       = '0;
         vy_in       = '0;
         ocol_in     = '0;
         orow_in     = '0;
         pix_done_in = 1'b0;
         idle_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff     <= 1'b1;
         pix_done_ff <= 1'b0;
         vx_ff       <= '0;
         vy_ff       <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         lead_ff     <= '0;
      end else begin
         idle_ff     <= idle_in;
         pix_done_ff <= pix_done_in;
         vx_ff       <= vx_in;
         vy_ff       <= vy_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
         lead_ff     <= lead_in;
      end
      lw_ff <= cur_w;
      lh_ff <= cur_h;
      lr_ff <= cur_r;
   end

   // Row masks select the line-store taps that lie inside the image and the
   // window; column masks select the cells that lie in the result's window.
   logic [NT-1:0] rowmask_in, colmask_in;

   always_comb begin
      int oc_r;
      oc_r = int'(ocol_ff) + int'(cur_r);
      for (int k = 0; k < NT; k++) begin
         rowmask_in[k] = (k <= 2 * int'(cur_r)) && (int'(vy_ff) >= k)
                      && (int'(vy_ff) < int'(cur_h) + k);
         colmask_in[k] = (k <= 2 * int'(cur_r)) && (k <= oc_r)
                      && (k + int'(cur_w) > oc_r);
      end
   end

   // Stage 1 registers: gray weighting products and the step's masks.
   logic [CB-1:0] s1_addr_ff;
   logic [23:0]   s1_pr_ff, s1_pg_ff, s1_pb_ff;
   logic [NT-1:0] s1_rowmask_ff, s1_colmask_ff;
   logic          s1_emit_ff, s1_fend_ff, s1_fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= step;
      end
      s1_addr_ff    <= vx_ff;
      s1_pb_ff      <= 24'(WEIGHT_BLUE)  * 24'(req_tdata[7:0]);
      s1_pg_ff      <= 24'(WEIGHT_GREEN) * 24'(req_tdata[15:8]);
      s1_pr_ff      <= 24'(WEIGHT_RED)   * 24'(req_tdata[23:16]);
      s1_rowmask_ff <= rowmask_in;
      s1_colmask_ff <= colmask_in;
      s1_emit_ff    <= emit;
      s1_fend_ff    <= fend;
      // With one-pixel rows the next read hits the address written now.
      s1_fwd_ff     <= s1_valid_ff && step && (s1_addr_ff == vx_ff);
   end

   // Line stores: store k holds the row k+1 above the newest at each column.
   logic [23:0]   gray_sum;
   logic [7:0]    tap   [NT];
   logic [7:0]    ram_q [NR];
   logic [7:0]    s2_tap_ff [NT];

   assign gray_sum = s1_pr_ff + s1_pg_ff + s1_pb_ff;

   always_comb begin
      tap[0] = gray_sum[23:16];
      for (int k = 1; k < NT; k++) begin
         tap[k] = s1_fwd_ff ? s2_tap_ff[k-1] : ram_q[k-1];
      end
   end

   for (genvar k = 0; k < NR; k++) begin : g_line
      gmm_ram #(
         .WIDTH (8),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (s1_valid_ff),
         .wr_addr (s1_addr_ff),
         .wr_data (tap[k]),
         .rd_addr (vx_ff),
         .rd_data (ram_q[k])
      );
   end

   // Stage 2 registers: the column of taps.
   logic [NT-1:0] s2_rowmask_ff, s2_colmask_ff;
   logic          s2_emit_ff, s2_fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         s2_tap_ff <= tap;
      end
      s2_rowmask_ff <= s1_rowmask_ff;
      s2_colmask_ff <= s1_colmask_ff;
      s2_emit_ff    <= s1_emit_ff;
      s2_fend_ff    <= s1_fend_ff;
   end

   // Column extremes enter the cell row.
   mm_type col_mm;
   mm_type cell_q [NT];

   always_comb begin
      col_mm.max_v = GRAY_MIN;
      col_mm.min_v = GRAY_MAX;
      for (int k = 0; k < NT; k++) begin
         if (s2_rowmask_ff[k] && (s2_tap_ff[k] > col_mm.max_v)) begin
            col_mm.max_v = s2_tap_ff[k];
         end
         if (s2_rowmask_ff[k] && (s2_tap_ff[k] < col_mm.min_v)) begin
            col_mm.min_v = s2_tap_ff[k];
         end
      end
   end

   for (genvar j = 0; j < NT; j++) begin : g_cell
      gmm_cell u_cell (
         .clock (clock),
         .shift (s2_valid_ff),
         .d_in  ((j == 0) ? col_mm : cell_q[(j == 0) ? 0 : j - 1]),
         .q_out (cell_q[j])
      );
   end

   // Stage 3: window extremes over the selected cells.
   logic [NT-1:0] s3_colmask_ff;
   logic          s3_fend_ff;
   logic [7:0]    win_max, win_min, win_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff && s2_emit_ff;
      end
      s3_colmask_ff <= s2_colmask_ff;
      s3_fend_ff    <= s2_fend_ff;
   end

   always_comb begin
      win_max = GRAY_MIN;
      win_min = GRAY_MAX;
      for (int j = 0; j < NT; j++) begin
         if (s3_colmask_ff[j] && (cell_q[j].max_v > win_max)) begin
            win_max = cell_q[j].max_v;
         end
         if (s3_colmask_ff[j] && (cell_q[j].min_v < win_min)) begin
            win_min = cell_q[j].min_v;
         end
      end
      win_range = win_max - win_min;
   end

   // Result queue. Admission above keeps it from overflowing.
   logic [8:0]         fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic               pop;

   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (s3_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + (FIFO_AW + 1)'(s3_valid_ff)
                      - (FIFO_AW + 1)'(pop);
      end
      if (s3_valid_ff) begin
         fifo_mem_ff[wr_ptr_ff] <= {s3_fend_ff, win_range};
      end
   end

   assign rsp_tdata = fifo_mem_ff[rd_ptr_ff][7:0];
   assign rsp_tlast = fifo_mem_ff[rd_ptr_ff][8];

endmodule

/* hdl/gmm_checker.sv */
// Port-level checks of the gray max-min window filter, bound to its top level.
// Depends on gray_maxmin_window_filter_top.
module gmm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind gray_maxmin_window_filter_top gmm_checker u_gmm_checker (.*);
